// ----- rtl/gsc_pkg.sv -----
package gsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DISC_W     = 16;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 8;
    localparam int RES_W      = 32;
    localparam int CMP_W      = 32;
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN_AIR  = 3'd5;

    localparam logic [DISC_W-1:0] RST_DISCONNECT = 16'd1000;
    localparam logic [23:0]       RST_PREHEAT    = 24'd20000;
    localparam logic [15:0]       RST_INTERVAL   = 16'd50;
    localparam logic [7:0]        RST_SAMPLES    = 8'd5;
    localparam logic [15:0]       RST_LOAD_RES   = 16'd2560;
    localparam logic [15:0]       RST_CLEAN_AIR  = 16'd17920;

    localparam logic [1:0] MODE_NC    = 2'd0;
    localparam logic [1:0] MODE_HEAT  = 2'd1;
    localparam logic [1:0] MODE_CAL   = 2'd2;
    localparam logic [1:0] MODE_READY = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [RES_W-1:0] sat32(input logic [DIV_NUM_W-1:0] v);
        logic [RES_W-1:0] r;
        r = (|v[DIV_NUM_W-1:RES_W]) ? {RES_W{1'b1}} : v[RES_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/gsc_divider.sv -----
module gsc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  gsc_pkg::div_req_t req,
    output gsc_pkg::div_rsp_t rsp
);
    import gsc_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_NUM_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_next  = {quo_reg[DIV_NUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/gas_sensor_calibration_fsm_unit.sv -----
// A tick that takes no resistance sample passes the accept, evaluate and result states.
// A sampling tick adds the Rs division on the shared 48-step divider (skipped for a zero
// reading) and an accumulate step; a tick that closes an average adds up to three more
// divisions.
// One tick at a time: the input is stalled from acceptance until the result transfers.
// Reset (rst_n, async, active low): registers return to defaults, mode not connected,
// all stores and timers cleared.
module gas_sensor_calibration_fsm_unit #(
    parameter int ADC_BITS   = 10,
    parameter int TIMER_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [gsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ADC_BITS-1:0]             adc_sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      sensor_status,
    output logic [31:0]                     sensor_resistance,
    output logic [31:0]                     baseline_resistance,
    output logic [31:0]                     resistance_ratio,
    output logic                            ratio_valid,
    output logic                            average_done
);
    import gsc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EVAL    = 4'd1;
    localparam logic [3:0] S_RS_GO   = 4'd2;
    localparam logic [3:0] S_RS_WAIT = 4'd3;
    localparam logic [3:0] S_ACC     = 4'd4;
    localparam logic [3:0] S_AVG     = 4'd5;
    localparam logic [3:0] S_BASE    = 4'd6;
    localparam logic [3:0] S_RATIO   = 4'd7;
    localparam logic [3:0] S_RAT_WT  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [DISC_W-1:0]     disc_reg;
    logic [23:0]           preheat_reg;
    logic [15:0]           interval_reg;
    logic [7:0]            spa_reg;
    logic [15:0]           load_reg;
    logic [15:0]           caf_reg;

    logic [3:0]            state_reg, state_next;
    logic [1:0]            mode_reg, mode_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [ADC_BITS-1:0]   ref_reg, ref_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [RES_W-1:0]      base_reg, base_next;
    logic [RES_W-1:0]      rs_reg, rs_next;
    logic                  measured_reg, measured_next;
    logic [RES_W-1:0]      ratio_reg, ratio_next;
    logic                  done_reg, done_next;
    logic [ADC_BITS-1:0]   raw_reg, raw_next;
    logic [RES_W-1:0]      sample_reg, sample_next;
    logic [RES_W-1:0]      prod_reg;

    logic [TIMER_BITS-1:0] et_inc;
    logic [ADC_BITS-1:0]   diff;
    logic [SUM_W-1:0]      sum_add;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      n_eff;
    logic                  valid_now;

    gsc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_reg     <= RST_DISCONNECT;
            preheat_reg  <= RST_PREHEAT;
            interval_reg <= RST_INTERVAL;
            spa_reg      <= RST_SAMPLES;
            load_reg     <= RST_LOAD_RES;
            caf_reg      <= RST_CLEAN_AIR;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DISCONNECT: disc_reg     <= DISC_W'(cfg_data[ADC_BITS-1:0]);
                CFG_PREHEAT:    preheat_reg  <= cfg_data[23:0];
                CFG_INTERVAL:   interval_reg <= cfg_data[15:0];
                CFG_SAMPLES:    spa_reg      <= cfg_data[7:0];
                CFG_LOAD_RES:   load_reg     <= cfg_data[15:0];
                CFG_CLEAN_AIR:  caf_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign et_inc  = (elapsed_reg == TIMER_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign diff    = (raw_reg > ref_reg) ? raw_reg - ref_reg : ref_reg - raw_reg;
    assign sum_add = sum_reg + SUM_W'(sample_reg);
    assign cnt_inc = count_reg + 1'b1;
    assign n_eff   = (spa_reg == '0) ? CNT_W'(1) : spa_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        elapsed_next  = elapsed_reg;
        ref_next      = ref_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        rs_next       = rs_reg;
        measured_next = measured_reg;
        ratio_next    = ratio_reg;
        done_next     = done_reg;
        raw_next      = raw_reg;
        sample_next   = sample_reg;
        div_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next   = adc_sample;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                done_next    = 1'b0;
                elapsed_next = et_inc;
                state_next   = S_OUT;
                if (DISC_W'(raw_reg) >= disc_reg)
                    mode_next = MODE_NC;
                else if (mode_reg == MODE_NC)
                begin
                    mode_next    = MODE_HEAT;
                    elapsed_next = '0;
                    ref_next     = raw_reg;
                end
                else if (mode_reg == MODE_HEAT)
                begin
                    if (diff > ADC_BITS'(1))
                    begin
                        elapsed_next = '0;
                        ref_next     = raw_reg;
                    end
                    else if (CMP_W'(et_inc) >= CMP_W'(preheat_reg))
                    begin
                        mode_next    = MODE_CAL;
                        sum_next     = '0;
                        count_next   = '0;
                        elapsed_next = '0;
                    end
                end
                else if (CMP_W'(et_inc) >= CMP_W'(interval_reg))
                begin
                    elapsed_next = '0;
                    if (raw_reg == '0)
                    begin
                        sample_next = {RES_W{1'b1}};
                        state_next  = S_ACC;
                    end
                    else
                        state_next = S_RS_GO;
                end
            end
            S_RS_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(prod_reg);
                div_req.den   = DIV_DEN_W'(raw_reg);
                state_next    = S_RS_WAIT;
            end
            S_RS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    sample_next = div_rsp.quotient[RES_W-1:0];
                    state_next  = S_ACC;
                end
            end
            S_ACC:
            begin
                if (cnt_inc >= n_eff)
                begin
                    sum_next      = '0;
                    count_next    = '0;
                    done_next     = 1'b1;
                    div_req.start = 1'b1;
                    div_req.num   = DIV_NUM_W'(sum_add);
                    div_req.den   = DIV_DEN_W'(n_eff);
                    state_next    = S_AVG;
                end
                else
                begin
                    sum_next   = sum_add;
                    count_next = cnt_inc;
                    state_next = S_OUT;
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    if (mode_reg == MODE_CAL)
                    begin
                        if (caf_reg == '0)
                        begin
                            base_next  = {RES_W{1'b1}};
                            mode_next  = MODE_READY;
                            state_next = S_RATIO;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            div_req.num   = {div_rsp.quotient[SUM_W-1:0], 8'd0};
                            div_req.den   = DIV_DEN_W'(caf_reg);
                            state_next    = S_BASE;
                        end
                    end
                    else
                    begin
                        rs_next       = sat32(div_rsp.quotient);
                        measured_next = 1'b1;
                        state_next    = S_RATIO;
                    end
                end
            end
            S_BASE:
            begin
                if (div_rsp.done)
                begin
                    base_next  = sat32(div_rsp.quotient);
                    mode_next  = MODE_READY;
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                // ratio cache follows every change of either store
                if (base_reg == '0)
                begin
                    ratio_next = {RES_W{1'b1}};
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {rs_reg, 16'd0};
                    div_req.den   = base_reg;
                    state_next    = S_RAT_WT;
                end
            end
            S_RAT_WT:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = sat32(div_rsp.quotient);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= MODE_NC;
            elapsed_reg  <= '0;
            ref_reg      <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            base_reg     <= '0;
            rs_reg       <= '0;
            measured_reg <= 1'b0;
            ratio_reg    <= {RES_W{1'b1}};
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            elapsed_reg  <= elapsed_next;
            ref_reg      <= ref_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            base_reg     <= base_next;
            rs_reg       <= rs_next;
            measured_reg <= measured_next;
            ratio_reg    <= ratio_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg    <= raw_next;
        sample_reg <= sample_next;
        prod_reg   <= RES_W'(load_reg) * {{(RES_W-ADC_BITS){1'b0}}, ~raw_reg};
    end

    assign valid_now = (mode_reg == MODE_READY) && measured_reg;

    assign in_stall            = (state_reg != S_IDLE);
    assign out_valid           = (state_reg == S_OUT);
    assign sensor_status       = mode_reg;
    assign sensor_resistance   = rs_reg;
    assign baseline_resistance = base_reg;
    assign resistance_ratio    = valid_now ? ratio_reg : '0;
    assign ratio_valid         = valid_now;
    assign average_done        = done_reg;

endmodule

// ----- bench/gas_sensor_calibration_fsm_unit_test.sv -----
`timescale 1ns / 100ps

module gas_sensor_calibration_fsm_unit_test;
    import gsc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_LEN = 400;
    localparam logic [9:0] FULL_SCALE = 10'h3FF;
    localparam logic [23:0] TIMER_TOP = 24'hFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rs;
        logic [31:0] ro;
        logic [31:0] ratio;
        logic        valid;
        logic        done;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [9:0]            adc_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [1:0]            sensor_status;
    logic [31:0]           sensor_resistance;
    logic [31:0]           baseline_resistance;
    logic [31:0]           resistance_ratio;
    logic                  ratio_valid;
    logic                  average_done;

    // register copies
    logic [9:0]  lvl_disconnect;
    logic [23:0] ticks_preheat;
    logic [15:0] ticks_interval;
    logic [7:0]  avg_samples;
    logic [15:0] r_load;
    logic [15:0] air_factor;

    // sensor state copies
    logic [1:0]  mode;
    logic [23:0] elapsed;
    logic [9:0]  ref_level;
    logic [39:0] rs_sum;
    logic [7:0]  rs_count;
    logic [31:0] ro_kohm;
    logic [31:0] rs_kohm;
    logic        rs_seen;

    logic [9:0] adc_ticks[$];
    reading_t   pending_readings[$];
    reading_t   want;
    logic       in_fire = 1'b0;
    logic       hold_start = 1'b0;
    int         hold_cycles = 0;
    int         send_idle = 0;
    int         recv_idle = 0;
    int         accepted_ticks = 0;
    int         checked_readings = 0;
    int         quiet_cycles = 0;
    int         mismatches = 0;

    gas_sensor_calibration_fsm_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .adc_sample(adc_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sensor_status(sensor_status),
        .sensor_resistance(sensor_resistance),
        .baseline_resistance(baseline_resistance),
        .resistance_ratio(resistance_ratio),
        .ratio_valid(ratio_valid),
        .average_done(average_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] rs_of_sample(input logic [9:0] raw);
        if (raw == 10'd0)
            return 32'hFFFF_FFFF;
        return clip32((64'(r_load) * (64'(FULL_SCALE) - 64'(raw))) / 64'(raw));
    endfunction

    function automatic reading_t sensor_tick(input logic [9:0] raw);
        reading_t    r;
        logic [9:0]  diff;
        logic [7:0]  n;
        logic [39:0] avg;
        logic [63:0] wide;
        r = '0;
        if (elapsed != TIMER_TOP)
            elapsed = elapsed + 24'd1;
        if (raw >= lvl_disconnect)
            mode = MODE_NC;
        else if (mode == MODE_NC)
        begin
            mode = MODE_HEAT;
            elapsed = '0;
            ref_level = raw;
        end
        else if (mode == MODE_HEAT)
        begin
            diff = (raw > ref_level) ? raw - ref_level : ref_level - raw;
            if (diff > 10'd1)
            begin
                elapsed = '0;
                ref_level = raw;
            end
            else if (elapsed >= ticks_preheat)
            begin
                mode = MODE_CAL;
                rs_sum = '0;
                rs_count = '0;
                elapsed = '0;
            end
        end
        else if (elapsed >= 24'(ticks_interval))
        begin
            n = (avg_samples == 8'd0) ? 8'd1 : avg_samples;
            elapsed = '0;
            rs_sum = rs_sum + 40'(rs_of_sample(raw));
            rs_count = rs_count + 8'd1;
            if (rs_count >= n)
            begin
                avg = rs_sum / 40'(n);
                rs_sum = '0;
                rs_count = '0;
                r.done = 1'b1;
                if (mode == MODE_CAL)
                begin
                    if (air_factor == 16'd0)
                        ro_kohm = 32'hFFFF_FFFF;
                    else
                    begin
                        wide = (64'(avg) << 8) / 64'(air_factor);
                        ro_kohm = clip32(wide);
                    end
                    mode = MODE_READY;
                end
                else
                begin
                    rs_kohm = clip32(64'(avg));
                    rs_seen = 1'b1;
                end
            end
        end
        r.status = mode;
        r.rs = rs_kohm;
        r.ro = ro_kohm;
        r.valid = (mode == MODE_READY) && rs_seen;
        if (r.valid)
            r.ratio = (ro_kohm == 32'd0) ? 32'hFFFF_FFFF
                                         : clip32((64'(rs_kohm) << 16) / 64'(ro_kohm));
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_DISCONNECT: lvl_disconnect = val[9:0];
            CFG_PREHEAT:    ticks_preheat = val[23:0];
            CFG_INTERVAL:   ticks_interval = val[15:0];
            CFG_SAMPLES:    avg_samples = val[7:0];
            CFG_LOAD_RES:   r_load = val[15:0];
            CFG_CLEAN_AIR:  air_factor = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [9:0] disc, input logic [23:0] pre,
                             input logic [15:0] intv, input logic [7:0] samp,
                             input logic [15:0] load, input logic [15:0] caf);
        write_reg(CFG_DISCONNECT, 24'(disc));
        write_reg(CFG_PREHEAT, pre);
        write_reg(CFG_INTERVAL, 24'(intv));
        write_reg(CFG_SAMPLES, 24'(samp));
        write_reg(CFG_LOAD_RES, 24'(load));
        write_reg(CFG_CLEAN_AIR, 24'(caf));
    endtask

    task automatic drain();
        while (adc_ticks.size() != 0 || in_valid || accepted_ticks != checked_readings)
            @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (adc_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle)
            begin
                in_valid <= 1'b1;
                adc_sample <= adc_ticks.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_start && hold_cycles < HOLD_LEN)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            pending_readings.push_back(sensor_tick(adc_sample));
            accepted_ticks <= accepted_ticks + 1;
        end
        if (out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("reading with none pending: status %0d", sensor_status);
                mismatches++;
            end
            else
            begin
                want = pending_readings.pop_front();
                checked_readings <= checked_readings + 1;
                if (sensor_status !== want.status)
                begin
                    $error("sensor_status: expected %0d, got %0d", want.status, sensor_status);
                    mismatches++;
                end
                if (sensor_resistance !== want.rs)
                begin
                    $error("sensor_resistance: expected %0h, got %0h", want.rs,
                           sensor_resistance);
                    mismatches++;
                end
                if (baseline_resistance !== want.ro)
                begin
                    $error("baseline_resistance: expected %0h, got %0h", want.ro,
                           baseline_resistance);
                    mismatches++;
                end
                if (resistance_ratio !== want.ratio)
                begin
                    $error("resistance_ratio: expected %0h, got %0h", want.ratio,
                           resistance_ratio);
                    mismatches++;
                end
                if (ratio_valid !== want.valid)
                begin
                    $error("ratio_valid: expected %0b, got %0b", want.valid, ratio_valid);
                    mismatches++;
                end
                if (average_done !== want.done)
                begin
                    $error("average_done: expected %0b, got %0b", want.done, average_done);
                    mismatches++;
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("gas_sensor_calibration_fsm_unit_test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int         ph;
        int         k;
        int         pick;
        int         nudge;
        logic [9:0] disc;
        logic [9:0] level;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        adc_sample = '0;
        out_stall = 1'b0;

        lvl_disconnect = 10'(RST_DISCONNECT);
        ticks_preheat = RST_PREHEAT;
        ticks_interval = RST_INTERVAL;
        avg_samples = RST_SAMPLES;
        r_load = RST_LOAD_RES;
        air_factor = RST_CLEAN_AIR;
        mode = MODE_NC;
        elapsed = '0;
        ref_level = '0;
        rs_sum = '0;
        rs_count = '0;
        ro_kohm = '0;
        rs_kohm = '0;
        rs_seen = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 27;
        recv_idle = 76;

        // reset defaults: disconnect edge, connect, small drift, restart
        @(posedge clk);
        adc_ticks = '{10'd1000, 10'd999, 10'd998, 10'd995};
        drain();

        // saturated Rs on a zero reading, then a measured Rs
        configure(10'd1023, 24'd1, 16'd1, 8'd1, 16'hFFFF, 16'hFFFF);
        @(posedge clk);
        adc_ticks = '{10'd1023, 10'd0, 10'd0, 10'd0, 10'd1022, 10'd512, 10'd1};
        drain();

        // disconnect level of zero: every reading counts as absent
        write_reg(CFG_DISCONNECT, 24'd0);
        @(posedge clk);
        adc_ticks = '{10'd0, 10'd1023};
        drain();

        // reconnect with a zero baseline and zero samples per average
        write_reg(CFG_DISCONNECT, 24'd1023);
        write_reg(CFG_LOAD_RES, 24'd1);
        write_reg(CFG_SAMPLES, 24'd0);
        @(posedge clk);
        adc_ticks = '{10'd1022, 10'd1022, 10'd1022, 10'd1022};
        drain();

        // zero clean-air factor
        write_reg(CFG_CLEAN_AIR, 24'd0);
        write_reg(CFG_SAMPLES, 24'd2);
        @(posedge clk);
        adc_ticks = '{10'd1023, 10'd5, 10'd5, 10'd5, 10'd5};
        drain();

        for (ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle = 76;
                recv_idle = 27;
            end
            if (ph == 8)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (ph % 4)
                0: disc = 10'd1023;
                1: disc = 10'($urandom_range(600, 1022));
                2: disc = 10'($urandom_range(256, 1023));
                default: disc = 10'($urandom_range(900, 1023));
            endcase
            configure(disc,
                      (ph == 3) ? 24'hFF_FFFF : 24'($urandom_range(1, 8)),
                      (ph == 6) ? 16'hFFFF : 16'($urandom_range(1, 4)),
                      (ph == 9) ? 8'd255 : 8'($urandom_range(1, 4)),
                      (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF
                                                    : 16'($urandom_range(1, 65535)),
                      (ph == 4) ? 16'd1 : (ph == 7) ? 16'hFFFF
                                                    : 16'($urandom_range(1, 65535)));
            @(posedge clk);
            if (ph == 1)
                hold_start = 1'b1;
            level = 10'($urandom_range(0, disc - 10'd1));
            for (k = 0; k < 40; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                begin
                    nudge = $urandom_range(0, 2);
                    if (nudge == 0 && level != 10'd0)
                        level = level - 10'd1;
                    else if (nudge == 2 && level != FULL_SCALE)
                        level = level + 10'd1;
                    adc_ticks.push_back(level);
                end
                else if (pick < 88)
                begin
                    level = 10'($urandom_range(0, 1023));
                    adc_ticks.push_back(level);
                end
                else if (pick < 94)
                    adc_ticks.push_back(10'($urandom_range(disc, 1023)));
                else
                begin
                    level = (level > 10'd8) ? level - 10'($urandom_range(2, 6))
                                            : level + 10'($urandom_range(2, 6));
                    adc_ticks.push_back(level);
                end
            end
            drain();
        end

        repeat (300) @(posedge clk);
        @(negedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d readings never arrived", pending_readings.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("gas_sensor_calibration_fsm_unit_test passed");
        else
            $display("gas_sensor_calibration_fsm_unit_test failed");
        $finish;
    end

endmodule
